[rtl/assert_macros.svh]
// Assertion macros of the sorted key table, included by sorted_key_table.sv.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define SKT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define SKT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/skt_pkg.sv]
// Package of the sorted key table: sizes, operation and status codes, types
// and the key helper functions. It depends on nothing.
`default_nettype none

package skt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int KEY_BYTES   = 8;

  localparam int KEY_W    = 8 * KEY_BYTES;
  localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int IN_KEY_W = 64;
  localparam int HND_W    = 16;
  localparam int KIND_W   = 2;
  localparam int STAT_W   = 2;
  localparam int POS_W    = 5;
  localparam int ECNT_W   = 6;

  localparam logic [KIND_W-1:0] K_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] K_FIND   = 2'd1;
  localparam logic [KIND_W-1:0] K_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [HND_W-1:0] hnd;
  } skt_entry_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } skt_flag_t;

  typedef struct packed {
    logic             cmp;
    logic             ins;
    logic             del;
    logic [KEY_W-1:0] key;
    skt_entry_t       new_ent;
  } skt_cmd_t;

  // Keys compare as text: every byte after the first zero byte is dropped.
  function automatic logic [KEY_W-1:0] canon_key(input logic [IN_KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    logic             ended;
    logic [7:0]       ch;
    r     = '0;
    ended = 1'b0;
    for (int b = KEY_BYTES - 1; b >= 0; b--) begin
      ch = k[8*b +: 8];
      if (ch == 8'h00) ended = 1'b1;
      if (!ended) r[8*b +: 8] = ch;
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] onehot_idx(input logic [TABLE_DEPTH-1:0] oh);
    logic [CNT_W-1:0] r;
    r = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (oh[i]) r = r | CNT_W'(i);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/skt_in_if.sv]
// Input channel of the sorted key table: valid, ready and one operation word.
// It depends on skt_pkg.
`default_nettype none

interface skt_in_if import skt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [IN_KEY_W-1:0] key;
  logic [HND_W-1:0]    handle;

  modport source (output valid, kind, key, handle, input ready);
  modport sink   (input valid, kind, key, handle, output ready);
endinterface

`default_nettype wire

[rtl/skt_out_if.sv]
// Result channel of the sorted key table: valid, ready and one result word.
// It depends on skt_pkg.
`default_nettype none

interface skt_out_if import skt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [POS_W-1:0]  position;
  logic [HND_W-1:0]  found_handle;
  logic [ECNT_W-1:0] entry_count;

  modport source (output valid, status, position, found_handle, entry_count, input ready);
  modport sink   (input valid, status, position, found_handle, entry_count, output ready);
endinterface

`default_nettype wire

[rtl/skt_cell.sv]
// One cell of the sorted key table: it holds one entry, compares it with the
// operation key and shifts entries to or from its neighbors. Uses skt_pkg.
`default_nettype none

module skt_cell import skt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire skt_cmd_t   cmd,
  input  wire logic       valid,
  input  wire logic       at_count,
  input  wire skt_entry_t prev_ent,
  input  wire skt_entry_t next_ent,
  input  wire logic       prev_gt,
  input  wire logic       next_eq,
  output skt_entry_t      ent,
  output skt_flag_t       flag
);

  skt_entry_t ent_r;
  logic       gt_r;
  logic       eq_r;
  logic       last_eq;

  assign last_eq = eq_r & ~next_eq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gt_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (cmd.cmp) begin
      gt_r <= valid & (ent_r.key > cmd.key);
      eq_r <= valid & (ent_r.key == cmd.key);
    end
  end

  // An insert opens a gap at the first greater entry; a delete closes the
  // gap left by the last equal entry.
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (prev_gt) begin
        ent_r <= prev_ent;
      end else if (gt_r || at_count) begin
        ent_r <= cmd.new_ent;
      end
    end else if (cmd.del && (last_eq || gt_r)) begin
      ent_r <= next_ent;
    end
  end

  assign ent     = ent_r;
  assign flag.gt = gt_r;
  assign flag.eq = eq_r;

endmodule

`default_nettype wire

[rtl/sorted_key_table.sv]
// Sorted key table: a row of cells keeps up to TABLE_DEPTH entries in key
// order. At the accepting edge every cell compares its key with the new
// key; in the update state that follows, the whole row shifts in one
// step while the result is registered. A new word is accepted in the cycle
// after that update. If the previous result has not been taken, the update
// waits for the result register. Entries need no clearing after reset.
`default_nettype none
`include "assert_macros.svh"

module sorted_key_table import skt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  skt_in_if.sink    in_if,
  skt_out_if.source out_if
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_UPD  = 1'b1;

  logic              state_r;
  logic [CNT_W-1:0]  count_r;
  logic [KIND_W-1:0] op_kind_r;
  skt_entry_t        op_ent_r;

  logic              out_valid_r;
  logic [STAT_W-1:0] res_status_r;
  logic [POS_W-1:0]  res_pos_r;
  logic [HND_W-1:0]  res_hnd_r;
  logic [ECNT_W-1:0] res_cnt_r;

  logic acc_w;
  logic upd_w;
  logic full_w;
  logic hit_w;
  logic any_gt_w;

  skt_cmd_t   cmd;
  skt_entry_t ents  [TABLE_DEPTH];
  skt_flag_t  flags [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] gt_vec;
  logic [TABLE_DEPTH-1:0] eq_vec;
  logic [TABLE_DEPTH-1:0] first_gt;
  logic [TABLE_DEPTH-1:0] first_eq;
  logic [TABLE_DEPTH-1:0] last_eq;

  logic [HND_W-1:0]  hnd_first;
  logic [HND_W-1:0]  hnd_last;
  logic [STAT_W-1:0] status_nxt;
  logic [CNT_W-1:0]  pos_nxt;
  logic [HND_W-1:0]  hnd_nxt;
  logic [CNT_W-1:0]  count_nxt;
  logic [31:0]       pos_wide;
  logic [31:0]       cnt_wide;

  assign in_if.ready = (state_r == S_IDLE);
  assign acc_w       = in_if.valid & in_if.ready;
  assign upd_w       = (state_r == S_UPD) & (~out_valid_r | out_if.ready);
  assign full_w      = (count_r == CNT_W'(TABLE_DEPTH));

  assign cmd.cmp     = acc_w;
  assign cmd.ins     = upd_w & (op_kind_r == K_INSERT) & ~full_w;
  assign cmd.del     = upd_w & (op_kind_r == K_DELETE) & hit_w;
  assign cmd.key     = canon_key(in_if.key);
  assign cmd.new_ent = op_ent_r;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    skt_entry_t prev_ent;
    skt_entry_t next_ent;
    logic       prev_gt;
    logic       next_eq;

    if (g == 0) begin : g_first
      assign prev_ent = '0;
      assign prev_gt  = 1'b0;
    end else begin : g_mid
      assign prev_ent = ents[g-1];
      assign prev_gt  = flags[g-1].gt;
    end

    if (g == TABLE_DEPTH - 1) begin : g_last
      assign next_ent = ents[g];
      assign next_eq  = 1'b0;
    end else begin : g_inner
      assign next_ent = ents[g+1];
      assign next_eq  = flags[g+1].eq;
    end

    skt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .valid    (CNT_W'(g) < count_r),
      .at_count (CNT_W'(g) == count_r),
      .prev_ent (prev_ent),
      .next_ent (next_ent),
      .prev_gt  (prev_gt),
      .next_eq  (next_eq),
      .ent      (ents[g]),
      .flag     (flags[g])
    );

    assign gt_vec[g]   = flags[g].gt;
    assign eq_vec[g]   = flags[g].eq;
    assign first_gt[g] = flags[g].gt & ~prev_gt;
    assign first_eq[g] = flags[g].eq & ~((g == 0) ? 1'b0 : flags[(g == 0) ? 0 : g-1].eq);
    assign last_eq[g]  = flags[g].eq & ~next_eq;
  end

  assign hit_w    = |eq_vec;
  assign any_gt_w = |gt_vec;

  always_comb begin
    hnd_first = '0;
    hnd_last  = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (first_eq[i]) hnd_first = hnd_first | ents[i].hnd;
      if (last_eq[i])  hnd_last  = hnd_last  | ents[i].hnd;
    end
  end

  always_comb begin
    status_nxt = ST_OK;
    pos_nxt    = '0;
    hnd_nxt    = '0;
    count_nxt  = count_r;
    unique case (op_kind_r)
      K_INSERT: begin
        if (full_w) begin
          status_nxt = ST_FULL;
        end else begin
          pos_nxt   = any_gt_w ? onehot_idx(first_gt) : count_r;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      K_FIND: begin
        if (hit_w) begin
          pos_nxt = onehot_idx(first_eq);
          hnd_nxt = hnd_first;
        end else begin
          status_nxt = ST_MISS;
        end
      end
      K_DELETE: begin
        if (hit_w) begin
          pos_nxt   = onehot_idx(last_eq);
          hnd_nxt   = hnd_last;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = ST_MISS;
        end
      end
      default: begin
      end
    endcase
  end

  assign pos_wide = 32'(pos_nxt);
  assign cnt_wide = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc_w) begin
        state_r <= S_UPD;
      end else if (upd_w) begin
        state_r <= S_IDLE;
      end
      if (upd_w) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_w) begin
      op_kind_r    <= in_if.kind;
      op_ent_r.key <= canon_key(in_if.key);
      op_ent_r.hnd <= in_if.handle;
    end
    if (upd_w) begin
      res_status_r <= status_nxt;
      res_pos_r    <= pos_wide[POS_W-1:0];
      res_hnd_r    <= hnd_nxt;
      res_cnt_r    <= cnt_wide[ECNT_W-1:0];
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.status       = res_status_r;
  assign out_if.position     = res_pos_r;
  assign out_if.found_handle = res_hnd_r;
  assign out_if.entry_count  = res_cnt_r;

  `SKT_ASSERT(a_cnt_bound, count_r <= CNT_W'(TABLE_DEPTH), "entry count above table depth")
  `SKT_ASSERT(a_accept_upd, acc_w |=> (state_r == S_UPD), "accepted word skipped the update")
  `SKT_ASSERT(a_cnt_stable, !upd_w |=> $stable(count_r), "count changed outside an update")
  `SKT_ASSERT(a_first_eq, (state_r == S_UPD) |-> $onehot0(first_eq), "equal keys not contiguous")
  `SKT_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> (count_r == '0) && !out_valid_r, "reset left state")

endmodule

`default_nettype wire

[bench/sorted_key_table_tb.sv]
`timescale 1ns / 1ps
// Testbench of sorted_key_table: directed and random insert, find and delete
// words are checked against a behavioral copy of the sorted table.
// It depends on skt_pkg, skt_in_if, skt_out_if and the sorted_key_table RTL.

module sorted_key_table_tb;
  import skt_pkg::*;

  localparam logic [KIND_W-1:0] K_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [HND_W-1:0]  found_handle;
    logic [ECNT_W-1:0] entry_count;
  } table_result_t;

  logic clk = 1'b0;
  logic rst_n;

  skt_in_if  in_ch ();
  skt_out_if out_ch ();

  sorted_key_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  logic [KEY_W-1:0] tbl_key [TABLE_DEPTH];
  logic [HND_W-1:0] tbl_hnd [TABLE_DEPTH];
  int               tbl_count;

  table_result_t expected_results [$];

  bit in_idle_on;
  bit out_idle_on;
  int mismatches;
  int results_seen;
  int n_insert, n_full, n_find, n_delete, n_miss, n_unused, n_ops;

  always #5 clk = ~clk;

  // Keys compare as text, so everything after the first zero byte is dropped.
  function automatic logic [KEY_W-1:0] text_key(input logic [IN_KEY_W-1:0] raw);
    logic [KEY_W-1:0] r;
    bit               ended;
    r = '0;
    ended = 1'b0;
    for (int b = KEY_BYTES - 1; b >= 0; b--) begin
      if (raw[8*b +: 8] == 8'h00) ended = 1'b1;
      if (!ended) r[8*b +: 8] = raw[8*b +: 8];
    end
    return r;
  endfunction

  function automatic table_result_t table_apply(input logic [KIND_W-1:0] kind,
                                                input logic [IN_KEY_W-1:0] raw_key,
                                                input logic [HND_W-1:0] hnd);
    table_result_t    r;
    logic [KEY_W-1:0] k;
    int               slot;
    r = '0;
    k = text_key(raw_key);
    slot = -1;
    case (kind)
      K_INSERT: begin
        if (tbl_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot = tbl_count;
          for (int i = tbl_count - 1; i >= 0; i--) begin
            if (tbl_key[i] > k) slot = i;
          end
          for (int i = tbl_count; i > slot; i--) begin
            tbl_key[i] = tbl_key[i-1];
            tbl_hnd[i] = tbl_hnd[i-1];
          end
          tbl_key[slot] = k;
          tbl_hnd[slot] = hnd;
          tbl_count++;
          r.position = POS_W'(slot);
        end
      end
      K_FIND: begin
        for (int i = tbl_count - 1; i >= 0; i--) begin
          if (tbl_key[i] == k) slot = i;
        end
        if (slot < 0) begin
          r.status = ST_MISS;
        end else begin
          r.position = POS_W'(slot);
          r.found_handle = tbl_hnd[slot];
        end
      end
      K_DELETE: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_key[i] == k) slot = i;
        end
        if (slot < 0) begin
          r.status = ST_MISS;
        end else begin
          r.position = POS_W'(slot);
          r.found_handle = tbl_hnd[slot];
          for (int i = slot; i + 1 < tbl_count; i++) begin
            tbl_key[i] = tbl_key[i+1];
            tbl_hnd[i] = tbl_hnd[i+1];
          end
          tbl_count--;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = ECNT_W'(tbl_count);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_op(input logic [KIND_W-1:0] kind,
                         input logic [IN_KEY_W-1:0] op_key,
                         input logic [HND_W-1:0] hnd);
    int            gap;
    table_result_t want;
    gap = in_idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.kind   <= kind;
    in_ch.key    <= op_key;
    in_ch.handle <= hnd;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    want = table_apply(kind, op_key, hnd);
    expected_results.push_back(want);
    n_ops++;
    case (kind)
      K_INSERT: begin
        n_insert++;
        if (want.status == ST_FULL) n_full++;
      end
      K_FIND: n_find++;
      K_DELETE: n_delete++;
      default: n_unused++;
    endcase
    if (want.status == ST_MISS) n_miss++;
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_text();
    logic [KEY_W-1:0] k;
    logic [7:0]       alpha [4];
    int               len;
    alpha = '{8'h01, 8'h5A, 8'h80, 8'hFF};
    k = '0;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, KEY_BYTES) : $urandom_range(0, 2);
    for (int b = 0; b < len; b++) begin
      k[8*(KEY_BYTES-1-b) +: 8] = alpha[$urandom_range(0, 3)];
    end
    return k;
  endfunction

  // Half the time the bytes behind the terminating zero get random garbage.
  function automatic logic [IN_KEY_W-1:0] pad_junk(input logic [KEY_W-1:0] text);
    logic [IN_KEY_W-1:0] k;
    logic [IN_KEY_W-1:0] junk;
    bit                  ended;
    k = IN_KEY_W'(text);
    junk = {$urandom, $urandom};
    ended = 1'b0;
    if ($urandom_range(0, 1) == 1) begin
      for (int b = KEY_BYTES - 1; b >= 0; b--) begin
        if (ended) k[8*b +: 8] = junk[8*b +: 8];
        else if (k[8*b +: 8] == 8'h00) ended = 1'b1;
      end
    end
    return k;
  endfunction

  function automatic logic [IN_KEY_W-1:0] choose_key();
    if ($urandom_range(0, 15) == 0) return {$urandom, $urandom};
    if (tbl_count > 0 && $urandom_range(0, 3) != 0)
      return pad_junk(tbl_key[$urandom_range(0, tbl_count - 1)]);
    return pad_junk(pick_text());
  endfunction

  task automatic random_ops(input int n, input int w_ins, input int w_find, input int w_del);
    int                  r;
    logic [KIND_W-1:0]   kind;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < w_ins) kind = K_INSERT;
      else if (r < w_ins + w_find) kind = K_FIND;
      else if (r < w_ins + w_find + w_del) kind = K_DELETE;
      else kind = K_UNUSED;
      send_op(kind, choose_key(), HND_W'($urandom_range(0, 65535)));
    end
  endtask

  task automatic test_empty_table();
    send_op(K_FIND, 64'h4100_0000_0000_0000, 16'h1234);
    send_op(K_DELETE, 64'h0000_0000_0000_0000, 16'hFFFF);
    send_op(K_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
  endtask

  task automatic test_key_extremes();
    send_op(K_INSERT, 64'h0000_0000_0000_0000, 16'h0000);
    send_op(K_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    send_op(K_INSERT, 64'h4200_1234_5678_9ABC, 16'h00B0);
    send_op(K_FIND, 64'h00FF_FFFF_FFFF_FFFF, 16'h5555);
    send_op(K_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000);
    send_op(K_FIND, 64'h4200_FEDC_BA98_7654, 16'hAAAA);
    send_op(K_FIND, 64'hFFFF_FFFF_FFFF_FFFE, 16'h0000);
  endtask

  task automatic test_duplicates();
    send_op(K_INSERT, 64'h4100_0000_0000_0000, 16'h0001);
    send_op(K_INSERT, 64'h4100_AAAA_0000_0000, 16'h0002);
    send_op(K_INSERT, 64'h4100_0000_0000_5555, 16'h0003);
    send_op(K_FIND, 64'h4100_0000_0000_0000, 16'h0000);
    send_op(K_DELETE, 64'h4100_FFFF_FFFF_FFFF, 16'h0000);
    send_op(K_DELETE, 64'h4141_0000_0000_0000, 16'h0000);
    send_op(K_FIND, 64'h4100_0000_0000_0000, 16'h0000);
  endtask

  task automatic test_unused_kind();
    send_op(K_UNUSED, 64'h4100_0000_0000_0000, 16'hFFFF);
    send_op(K_UNUSED, 64'h0000_0000_0000_0000, 16'h0000);
  endtask

  task automatic test_drain_directed();
    send_op(K_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000);
    send_op(K_DELETE, 64'h0000_0000_0000_0000, 16'h0000);
    send_op(K_DELETE, 64'h4200_0000_0000_0000, 16'h0000);
    send_op(K_DELETE, 64'h4100_0000_0000_0000, 16'h0000);
    send_op(K_DELETE, 64'h4100_0000_0000_0000, 16'h0000);
  endtask

  task automatic test_fill_to_full();
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    random_ops(200, 65, 15, 15);
  endtask

  task automatic test_drain_back_to_back();
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    random_ops(150, 20, 25, 50);
  endtask

  task automatic test_refill_slow_sink();
    in_idle_on = 1'b0;
    out_idle_on = 1'b1;
    random_ops(150, 60, 20, 15);
  endtask

  task automatic test_mixed_slow_source();
    in_idle_on = 1'b1;
    out_idle_on = 1'b0;
    random_ops(150, 35, 30, 30);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = K_INSERT;
    in_ch.key = '0;
    in_ch.handle = '0;
    tbl_count = 0;
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_table();
    test_key_extremes();
    test_duplicates();
    test_unused_kind();
    test_drain_directed();
    test_fill_to_full();
    wait_all_results();
    test_drain_back_to_back();
    test_refill_slow_sink();
    wait_all_results();
    test_mixed_slow_source();

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d words: %0d inserts (%0d refused on a full table), %0d finds,",
             n_ops, n_insert, n_full, n_find);
    $display("%0d deletes, %0d unused codes; %0d finds or deletes missed, %0d results checked.",
             n_delete, n_unused, n_miss, results_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("sorted_key_table test passed");
    end else begin
      $display("sorted_key_table test failed");
    end
    $finish;
  end

  initial begin
    table_result_t want;
    int            stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = out_idle_on ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d position %0d count %0d",
                                  out_ch.status, out_ch.position, out_ch.entry_count));
      end else begin
        want = expected_results.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_ch.status, want.status));
        if (out_ch.position !== want.position)
          report_mismatch($sformatf("position %0d, expected %0d",
                                    out_ch.position, want.position));
        if (out_ch.found_handle !== want.found_handle)
          report_mismatch($sformatf("found_handle %h, expected %h",
                                    out_ch.found_handle, want.found_handle));
        if (out_ch.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, expected %0d",
                                    out_ch.entry_count, want.entry_count));
      end
      @(negedge clk);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timeout: no word moved for %0d cycles.", IDLE_LIMIT);
    $display("sorted_key_table test failed");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/skt_pkg.sv
rtl/skt_in_if.sv
rtl/skt_out_if.sv
rtl/skt_cell.sv
rtl/sorted_key_table.sv
bench/sorted_key_table_tb.sv
